// ----- rtl/gpo_pkg.sv -----
// Shared types, register codes and constants for the glyph pixel overlay unit.
`default_nettype none

package gpo_pkg;

  // Register file geometry: seven 32-bit registers at word addresses.
  localparam int unsigned RegCount = 7;
  localparam int unsigned AddrW    = 5;
  localparam int unsigned DataW    = 32;
  localparam int unsigned IdxW     = 3;

  // Register indexes.
  localparam logic [IdxW-1:0] RegMode     = 3'd0;
  localparam logic [IdxW-1:0] RegTextLuma = 3'd1;
  localparam logic [IdxW-1:0] RegTextCb   = 3'd2;
  localparam logic [IdxW-1:0] RegTextCr   = 3'd3;
  localparam logic [IdxW-1:0] RegEdgeLuma = 3'd4;
  localparam logic [IdxW-1:0] RegEdgeCb   = 3'd5;
  localparam logic [IdxW-1:0] RegEdgeCr   = 3'd6;

  // Drawing modes.
  localparam logic [2:0] ModeGrayXor    = 3'd0;
  localparam logic [2:0] ModeMonoXor    = 3'd1;
  localparam logic [2:0] ModeGrayBlend  = 3'd2;
  localparam logic [2:0] ModeMonoFill   = 3'd3;
  localparam logic [2:0] ModeMonoStroke = 3'd4;

  // Reset values of the registers.
  localparam logic [2:0] ModeReset     = ModeGrayBlend;
  localparam logic [7:0] TextLumaReset = 8'hFF;
  localparam logic [7:0] TextCbReset   = 8'h80;
  localparam logic [7:0] TextCrReset   = 8'h80;
  localparam logic [7:0] EdgeLumaReset = 8'h00;
  localparam logic [7:0] EdgeCbReset   = 8'h80;
  localparam logic [7:0] EdgeCrReset   = 8'h80;

  // Full-scale value used by the xor and blend paths.
  localparam logic [7:0] FullScale = 8'hFF;

  // Input beat: one pixel of glyph data and background.
  typedef struct packed {
    logic [7:0] coverage;
    logic [7:0] neighbour_bits;
    logic [7:0] back_luma;
    logic [7:0] back_cb;
    logic [7:0] back_cr;
  } in_beat_t;

  // Output beat: one composited pixel.
  typedef struct packed {
    logic [7:0] out_luma;
    logic [7:0] out_cb;
    logic [7:0] out_cr;
    logic       touched;
  } out_beat_t;

  // Configuration seen by the compositing logic.
  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] text_luma;
    logic [7:0] text_cb;
    logic [7:0] text_cr;
    logic [7:0] edge_luma;
    logic [7:0] edge_cb;
    logic [7:0] edge_cr;
  } cfg_t;

endpackage

`default_nettype wire

// ----- rtl/glyph_pixel_overlay_yuv_unit.sv -----
// Top level of the glyph pixel overlay unit: input register, compositing, result register.
// The unit takes one pixel beat per clock and returns one composited beat per clock while the
// consumer keeps taking results, so beats can follow back to back. An accepted beat lands in
// the input register, passes the compositing logic and is captured in the result register.
// The input register refills in the same cycle that its pixel moves on. A stalled consumer
// therefore holds back the input once both registers are full. The compositing logic between
// the two registers sets the clock period, not the beat rate: one 8x8 multiply pair and an add
// per color component. The user must see that registers are written through the APB-style port
// only while no pixel is in flight; the unit itself does not enforce this.
`default_nettype none

module glyph_pixel_overlay_yuv_unit (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output      logic                      in_ready_o,
  input  wire gpo_pkg::in_beat_t         in_beat_i,
  output      logic                      out_valid_o,
  input  wire logic                      out_ready_i,
  output      gpo_pkg::out_beat_t        out_beat_o,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [gpo_pkg::AddrW-1:0] paddr,
  input  wire logic [gpo_pkg::DataW-1:0] pwdata,
  output      logic [gpo_pkg::DataW-1:0] prdata,
  output      logic                      pready
);

  gpo_pkg::cfg_t      cfg;
  gpo_pkg::in_beat_t  pix_q;
  gpo_pkg::out_beat_t res_d;
  gpo_pkg::out_beat_t res_q;
  logic               pix_valid_q;
  logic               res_valid_q;
  logic               res_ready;
  logic               pix_load;
  logic               res_load;

  gpo_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Each stage takes a new beat when it is empty or its content moves on.
  assign res_ready  = ~res_valid_q | out_ready_i;
  assign in_ready_o = ~pix_valid_q | res_ready;
  assign pix_load   = in_valid_i & in_ready_o;
  assign res_load   = pix_valid_q & res_ready;

  // Input stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      pix_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_load) begin
      pix_q <= in_beat_i;
    end
  end

  gpo_compose u_compose (
    .pix_i (pix_q),
    .cfg_i (cfg),
    .res_o (res_d)
  );

  // Result stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_ready) begin
      res_valid_q <= pix_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_beat_o  = res_q;

endmodule

`default_nettype wire

// ----- rtl/gpo_regs.sv -----
// APB-style configuration registers of the glyph pixel overlay unit.
`default_nettype none

module gpo_regs (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [gpo_pkg::AddrW-1:0] paddr,
  input  wire logic [gpo_pkg::DataW-1:0] pwdata,
  output      logic [gpo_pkg::DataW-1:0] prdata,
  output      logic                      pready,
  output      gpo_pkg::cfg_t             cfg_o
);

  gpo_pkg::cfg_t             cfg_q;
  gpo_pkg::cfg_t             cfg_d;
  logic [gpo_pkg::IdxW-1:0]  reg_idx;
  logic                      wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[gpo_pkg::AddrW-1:2];
  assign wr_en   = psel & penable & pwrite;

  // Write decode; an index past the last register is ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        gpo_pkg::RegMode:     cfg_d.mode      = pwdata[2:0];
        gpo_pkg::RegTextLuma: cfg_d.text_luma = pwdata[7:0];
        gpo_pkg::RegTextCb:   cfg_d.text_cb   = pwdata[7:0];
        gpo_pkg::RegTextCr:   cfg_d.text_cr   = pwdata[7:0];
        gpo_pkg::RegEdgeLuma: cfg_d.edge_luma = pwdata[7:0];
        gpo_pkg::RegEdgeCb:   cfg_d.edge_cb   = pwdata[7:0];
        gpo_pkg::RegEdgeCr:   cfg_d.edge_cr   = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode      <= gpo_pkg::ModeReset;
      cfg_q.text_luma <= gpo_pkg::TextLumaReset;
      cfg_q.text_cb   <= gpo_pkg::TextCbReset;
      cfg_q.text_cr   <= gpo_pkg::TextCrReset;
      cfg_q.edge_luma <= gpo_pkg::EdgeLumaReset;
      cfg_q.edge_cb   <= gpo_pkg::EdgeCbReset;
      cfg_q.edge_cr   <= gpo_pkg::EdgeCrReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read mux, zero-extended to the bus width.
  always_comb begin
    prdata = '0;
    case (reg_idx)
      gpo_pkg::RegMode:     prdata = {29'd0, cfg_q.mode};
      gpo_pkg::RegTextLuma: prdata = {24'd0, cfg_q.text_luma};
      gpo_pkg::RegTextCb:   prdata = {24'd0, cfg_q.text_cb};
      gpo_pkg::RegTextCr:   prdata = {24'd0, cfg_q.text_cr};
      gpo_pkg::RegEdgeLuma: prdata = {24'd0, cfg_q.edge_luma};
      gpo_pkg::RegEdgeCb:   prdata = {24'd0, cfg_q.edge_cb};
      gpo_pkg::RegEdgeCr:   prdata = {24'd0, cfg_q.edge_cr};
      default:              prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/gpo_compose.sv -----
// Per-pixel compositing logic: xor, alpha blend, fill and stroke.
`default_nettype none

module gpo_compose (
  input  wire gpo_pkg::in_beat_t  pix_i,
  input  wire gpo_pkg::cfg_t      cfg_i,
  output      gpo_pkg::out_beat_t res_o
);

  logic        set;
  logic        edge_hit;
  logic [7:0]  inv_a;
  logic [15:0] mix_luma;
  logic [15:0] mix_cb;
  logic [15:0] mix_cr;

  assign set      = (pix_i.coverage != 8'd0);
  assign edge_hit = (pix_i.neighbour_bits != 8'd0);
  assign inv_a    = gpo_pkg::FullScale - pix_i.coverage;

  // Alpha blend per component; the sum stays below 2^16.
  assign mix_luma = 16'(pix_i.back_luma * inv_a) + 16'(cfg_i.text_luma * pix_i.coverage);
  assign mix_cb   = 16'(pix_i.back_cb * inv_a) + 16'(cfg_i.text_cb * pix_i.coverage);
  assign mix_cr   = 16'(pix_i.back_cr * inv_a) + 16'(cfg_i.text_cr * pix_i.coverage);

  // Mode select; anything not written passes the background through.
  always_comb begin
    res_o.out_luma = pix_i.back_luma;
    res_o.out_cb   = pix_i.back_cb;
    res_o.out_cr   = pix_i.back_cr;
    res_o.touched  = 1'b0;
    case (cfg_i.mode)
      gpo_pkg::ModeGrayXor: begin
        res_o.out_luma = pix_i.back_luma ^ pix_i.coverage;
        res_o.touched  = set;
      end
      gpo_pkg::ModeMonoXor: begin
        if (set) begin
          res_o.out_luma = pix_i.back_luma ^ gpo_pkg::FullScale;
          res_o.touched  = 1'b1;
        end
      end
      gpo_pkg::ModeGrayBlend: begin
        res_o.out_luma = mix_luma[15:8];
        res_o.out_cb   = mix_cb[15:8];
        res_o.out_cr   = mix_cr[15:8];
        res_o.touched  = 1'b1;
      end
      gpo_pkg::ModeMonoFill, gpo_pkg::ModeMonoStroke: begin
        if (set) begin
          res_o.out_luma = cfg_i.text_luma;
          res_o.out_cb   = cfg_i.text_cb;
          res_o.out_cr   = cfg_i.text_cr;
          res_o.touched  = 1'b1;
        end else if ((cfg_i.mode == gpo_pkg::ModeMonoStroke) && edge_hit) begin
          res_o.out_luma = cfg_i.edge_luma;
          res_o.out_cb   = cfg_i.edge_cb;
          res_o.out_cr   = cfg_i.edge_cr;
          res_o.touched  = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/gpo_checker.sv -----
// Port-level checker for the glyph pixel overlay unit, bound to the top level.
`default_nettype none

module gpo_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_valid_i,
  input wire logic                      in_ready_o,
  input wire gpo_pkg::in_beat_t         in_beat_i,
  input wire logic                      out_valid_o,
  input wire logic                      out_ready_i,
  input wire gpo_pkg::out_beat_t        out_beat_o,
  input wire logic                      psel,
  input wire logic                      penable,
  input wire logic                      pwrite,
  input wire logic [gpo_pkg::AddrW-1:0] paddr,
  input wire logic [gpo_pkg::DataW-1:0] pwdata,
  input wire logic [gpo_pkg::DataW-1:0] prdata,
  input wire logic                      pready
);

  // A waiting input beat stays offered and unchanged until it is taken.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_beat_i))
    else $error("input beat changed while waiting");

  // A stalled result beat holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_beat_o))
    else $error("result beat changed while stalled");

  // A result appears only after an input beat was accepted and has passed the input and result registers.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result beat without a matching input beat");

  // With the result stage empty, the input side is always open.
  a_no_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with an empty result stage");

  // A mode write reads back on the next cycle.
  a_mode_rb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready
      && (paddr[gpo_pkg::AddrW-1:2] == gpo_pkg::RegMode)
    ##1 (paddr[gpo_pkg::AddrW-1:2] == gpo_pkg::RegMode)
    |-> prdata[2:0] == $past(pwdata[2:0]))
    else $error("mode register readback mismatch");

endmodule

bind glyph_pixel_overlay_yuv_unit gpo_checker u_checker (.*);

`default_nettype wire

// ----- tb/sv/overlay_checker.sv -----
// Checker for the glyph pixel overlay unit: mirrors the registers, predicts and compares pixels.
`timescale 1ns / 1ps

module overlay_checker (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  input  wire logic                      in_ready_i,
  input  wire gpo_pkg::in_beat_t         in_beat_i,
  input  wire logic                      out_valid_i,
  input  wire logic                      out_ready_i,
  input  wire gpo_pkg::out_beat_t        out_beat_i,
  input  wire logic                      psel_i,
  input  wire logic                      penable_i,
  input  wire logic                      pwrite_i,
  input  wire logic [gpo_pkg::AddrW-1:0] paddr_i,
  input  wire logic [gpo_pkg::DataW-1:0] pwdata_i,
  input  wire logic                      pready_i,
  output int                             mismatch_count_o,
  output int                             pending_o,
  output int                             checked_o
);
  import gpo_pkg::*;

  // Local copy of the register file, updated from the write transfers seen on the port.
  cfg_t      overlay_cfg;
  // Composited pixels predicted for accepted input beats, oldest first.
  out_beat_t expected_pixels[$];

  // One color component of the alpha blend: (back*(255-a) + text*a) >> 8.
  function automatic logic [7:0] blend_channel(logic [7:0] back, logic [7:0] text,
                                               logic [7:0] alpha);
    logic [16:0] acc;
    acc = 17'(back) * 17'(FullScale - alpha) + 17'(text) * 17'(alpha);
    return acc[15:8];
  endfunction

  // Predicts the composited pixel for one input beat under the given settings.
  function automatic out_beat_t composite_pixel(in_beat_t px, cfg_t cfg);
    out_beat_t res;
    logic      lit;
    res.out_luma = px.back_luma;
    res.out_cb   = px.back_cb;
    res.out_cr   = px.back_cr;
    res.touched  = 1'b0;
    lit = (px.coverage != 8'h00);
    case (cfg.mode)
      ModeGrayXor: begin
        res.out_luma = px.back_luma ^ px.coverage;
        res.touched  = lit;
      end
      ModeMonoXor: begin
        if (lit) begin
          res.out_luma = px.back_luma ^ FullScale;
          res.touched  = 1'b1;
        end
      end
      ModeGrayBlend: begin
        res.out_luma = blend_channel(px.back_luma, cfg.text_luma, px.coverage);
        res.out_cb   = blend_channel(px.back_cb, cfg.text_cb, px.coverage);
        res.out_cr   = blend_channel(px.back_cr, cfg.text_cr, px.coverage);
        res.touched  = 1'b1;
      end
      ModeMonoFill, ModeMonoStroke: begin
        // A set mask bit always wins; the outline only lands on clear pixels.
        if (lit) begin
          res.out_luma = cfg.text_luma;
          res.out_cb   = cfg.text_cb;
          res.out_cr   = cfg.text_cr;
          res.touched  = 1'b1;
        end else if (cfg.mode == ModeMonoStroke && px.neighbour_bits != 8'h00) begin
          res.out_luma = cfg.edge_luma;
          res.out_cb   = cfg.edge_cb;
          res.out_cr   = cfg.edge_cr;
          res.touched  = 1'b1;
        end
      end
      default: begin
        // Spare mode codes pass the background through.
      end
    endcase
    return res;
  endfunction

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    mismatch_count_o++;
    $display("[%0t] mismatch on %s: got 0x%02h, expected 0x%02h", $time, what, got, want);
  endtask

  // Watch both channels and the register port at every rising edge.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_beat_t want;
    if (!rst_ni) begin
      overlay_cfg.mode      <= ModeReset;
      overlay_cfg.text_luma <= TextLumaReset;
      overlay_cfg.text_cb   <= TextCbReset;
      overlay_cfg.text_cr   <= TextCrReset;
      overlay_cfg.edge_luma <= EdgeLumaReset;
      overlay_cfg.edge_cb   <= EdgeCbReset;
      overlay_cfg.edge_cr   <= EdgeCrReset;
      expected_pixels.delete();
      mismatch_count_o = 0;
      pending_o        = 0;
      checked_o        = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        expected_pixels.push_back(composite_pixel(in_beat_i, overlay_cfg));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("result beat with nothing expected", out_beat_i.out_luma, 8'h00);
        end else begin
          want = expected_pixels.pop_front();
          checked_o++;
          if (out_beat_i.out_luma !== want.out_luma)
            report_mismatch("out_luma", out_beat_i.out_luma, want.out_luma);
          if (out_beat_i.out_cb !== want.out_cb)
            report_mismatch("out_cb", out_beat_i.out_cb, want.out_cb);
          if (out_beat_i.out_cr !== want.out_cr)
            report_mismatch("out_cr", out_beat_i.out_cr, want.out_cr);
          if (out_beat_i.touched !== want.touched)
            report_mismatch("touched", {7'd0, out_beat_i.touched}, {7'd0, want.touched});
        end
      end
      // Register write completes on the access cycle.
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[AddrW-1:2])
          RegMode:     overlay_cfg.mode      <= pwdata_i[2:0];
          RegTextLuma: overlay_cfg.text_luma <= pwdata_i[7:0];
          RegTextCb:   overlay_cfg.text_cb   <= pwdata_i[7:0];
          RegTextCr:   overlay_cfg.text_cr   <= pwdata_i[7:0];
          RegEdgeLuma: overlay_cfg.edge_luma <= pwdata_i[7:0];
          RegEdgeCb:   overlay_cfg.edge_cb   <= pwdata_i[7:0];
          RegEdgeCr:   overlay_cfg.edge_cr   <= pwdata_i[7:0];
          default: begin
          end
        endcase
      end
      pending_o = expected_pixels.size();
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// Top of the overlay unit testbench: clock, reset, pixel and register stimulus, verdict.
`timescale 1ns / 1ps

module tb_top;
  import gpo_pkg::*;

  // Mode codes that the unit leaves unused.
  localparam logic [2:0] ModeSpareFirst = 3'd5;
  localparam logic [2:0] ModeSpareLast  = 3'd7;

  localparam int PhaseCount  = 11;
  localparam int PhaseBeats  = 150;
  localparam int QuietBeats  = 230;
  localparam int HoldCycles  = 200;
  localparam int SettleCycles = 8;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  in_beat_t          in_beat   = '0;
  logic              out_ready = 1'b0;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [AddrW-1:0]  paddr     = '0;
  logic [DataW-1:0]  pwdata    = '0;
  logic              in_ready;
  logic              out_valid;
  out_beat_t         out_beat;
  logic [DataW-1:0]  prdata;
  logic              pready;

  int mismatch_count;
  int pending;
  int checked;

  // Knobs shared between the stimulus and the result sink, and the count of beats sent.
  bit quiet      = 1'b0;
  bit hold_req   = 1'b0;
  int idle_pct   = 10;
  int beats_sent = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  glyph_pixel_overlay_yuv_unit uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_beat_i   (in_beat),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_beat_o  (out_beat),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  overlay_checker pixel_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_beat_i        (in_beat),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_beat_i       (out_beat),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .pready_i         (pready),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending),
    .checked_o        (checked)
  );

  // One register write: setup cycle, then access cycle.
  task automatic write_reg(logic [IdxW-1:0] idx, logic [7:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Loads the font and stroke colors.
  task automatic load_palette(logic [7:0] ty, logic [7:0] tu, logic [7:0] tv,
                              logic [7:0] ey, logic [7:0] eu, logic [7:0] ev);
    write_reg(RegTextLuma, ty);
    write_reg(RegTextCb, tu);
    write_reg(RegTextCr, tv);
    write_reg(RegEdgeLuma, ey);
    write_reg(RegEdgeCb, eu);
    write_reg(RegEdgeCr, ev);
  endtask

  // Offers one pixel beat, maybe after an idle burst, and waits until it is taken.
  task automatic send_pixel(in_beat_t px);
    if (!quiet && $urandom_range(99, 0) < idle_pct) begin
      repeat ($urandom_range(6, 1)) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_beat  <= px;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  // Stops offering beats and waits until every predicted pixel has come back.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic in_beat_t pixel(logic [7:0] cov, logic [7:0] nb, logic [7:0] y,
                                     logic [7:0] u, logic [7:0] v);
    in_beat_t px;
    px.coverage       = cov;
    px.neighbour_bits = nb;
    px.back_luma      = y;
    px.back_cb        = u;
    px.back_cr        = v;
    return px;
  endfunction

  // Byte value biased toward the extremes and mid-scale.
  function automatic logic [7:0] pick_level();
    case ($urandom_range(9, 0))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      default: return 8'($urandom);
    endcase
  endfunction

  // Random pixel with plenty of clear pixels, single neighbors and full coverage.
  function automatic in_beat_t random_pixel();
    in_beat_t px;
    case ($urandom_range(9, 0))
      0, 1, 2: px.coverage = 8'h00;
      3:       px.coverage = 8'hFF;
      4:       px.coverage = 8'h01;
      default: px.coverage = 8'($urandom);
    endcase
    case ($urandom_range(5, 0))
      0, 1:    px.neighbour_bits = 8'h00;
      2:       px.neighbour_bits = 8'(1 << $urandom_range(7, 0));
      default: px.neighbour_bits = 8'($urandom);
    endcase
    px.back_luma = pick_level();
    px.back_cb   = pick_level();
    px.back_cr   = pick_level();
    return px;
  endfunction

  // Result sink: random stall bursts, plus one long hold-off on request.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HoldCycles - 1;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(99, 0) < idle_pct) begin
        stall_left = $urandom_range(5, 0);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Pixel and register stimulus, then the verdict.
  initial begin : stimulus
    int         phase;
    logic [2:0] mode_sel;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Blend with the reset palette: zero coverage still darkens, full coverage, extremes.
    send_pixel(pixel(8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF));
    send_pixel(pixel(8'hFF, 8'h00, 8'h00, 8'h00, 8'h00));
    send_pixel(pixel(8'h80, 8'hFF, 8'h3C, 8'hC3, 8'h80));
    drain();
    load_palette(8'h00, 8'hFF, 8'h5A, 8'hFF, 8'h00, 8'hA5);
    send_pixel(pixel(8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF));
    drain();

    // Gray xor: clear pixel passes, full and partial coverage flip luma.
    write_reg(RegMode, 8'(ModeGrayXor));
    send_pixel(pixel(8'h00, 8'hFF, 8'h12, 8'h34, 8'h56));
    send_pixel(pixel(8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF));
    send_pixel(pixel(8'h5A, 8'h00, 8'hA5, 8'h80, 8'h80));
    drain();

    // Mono xor: any nonzero coverage inverts luma.
    write_reg(RegMode, 8'(ModeMonoXor));
    send_pixel(pixel(8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00));
    send_pixel(pixel(8'h01, 8'h00, 8'h00, 8'h11, 8'h22));
    send_pixel(pixel(8'h80, 8'h00, 8'hFF, 8'h33, 8'h44));
    drain();

    // Mono fill: neighbors do not matter without stroke.
    write_reg(RegMode, 8'(ModeMonoFill));
    send_pixel(pixel(8'h00, 8'hFF, 8'h21, 8'h43, 8'h65));
    send_pixel(pixel(8'h01, 8'h00, 8'h87, 8'hA9, 8'hCB));
    drain();

    // Stroke: fill wins over outline, isolated clear pixel passes, edge neighbors outline.
    write_reg(RegMode, 8'(ModeMonoStroke));
    send_pixel(pixel(8'hFF, 8'hFF, 8'h10, 8'h20, 8'h30));
    send_pixel(pixel(8'h00, 8'h00, 8'h40, 8'h50, 8'h60));
    send_pixel(pixel(8'h00, 8'h01, 8'h70, 8'h80, 8'h90));
    send_pixel(pixel(8'h00, 8'h80, 8'hA0, 8'hB0, 8'hC0));
    drain();

    // Spare mode codes pass everything through.
    for (int m = ModeSpareFirst; m <= ModeSpareLast; m++) begin
      write_reg(RegMode, 8'(m));
      send_pixel(pixel(8'hFF, 8'hFF, 8'h5A, 8'hA5, 8'h3C));
      drain();
    end

    // Random phases, each under fresh settings; the first five walk the modes in order.
    for (phase = 0; phase < PhaseCount; phase++) begin
      if (phase < 5) begin
        mode_sel = ModeGrayXor + 3'(phase);
      end else if ($urandom_range(9, 0) == 0) begin
        mode_sel = 3'($urandom_range(ModeSpareLast, ModeSpareFirst));
      end else begin
        mode_sel = 3'($urandom_range(ModeMonoStroke, ModeGrayXor));
      end
      write_reg(RegMode, 8'(mode_sel));
      load_palette(pick_level(), pick_level(), pick_level(),
                   pick_level(), pick_level(), pick_level());
      idle_pct = $urandom_range(30, 0);
      // One phase stalls the sink for a long time while beats keep coming.
      if (phase == 2) begin
        idle_pct = 0;
        hold_req = 1'b1;
      end
      repeat (PhaseBeats) send_pixel(random_pixel());
      drain();
    end

    // Closing stretch at full rate on both sides.
    quiet = 1'b1;
    write_reg(RegMode, 8'(ModeMonoStroke));
    load_palette(pick_level(), pick_level(), pick_level(),
                 pick_level(), pick_level(), pick_level());
    repeat (QuietBeats) send_pixel(random_pixel());
    drain();
    repeat (SettleCycles) @(posedge clk);

    $display("Sent %0d pixel beats through all five drawing modes, the spare codes and %0d",
             beats_sent, PhaseCount + 1);
    $display("random register settings; %0d results checked, %0d mismatches.",
             checked, mismatch_count);
    if (mismatch_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog in case the handshake hangs.
  initial begin : watchdog
    #(2_000_000);
    $display("TB_ERROR");
    $finish;
  end

endmodule
